### hdl/rmc_pkg.sv
// Shared types and constants of the relay mode controller.
// Holds field widths, command, mode and register codes, sequencer states and weekday helpers.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rmc_pkg;

    localparam int CMD_W       = 3;
    localparam int MODE_W      = 3;
    localparam int SENSOR_W    = 24;
    localparam int HYST_W      = 22;
    localparam int SECS_W      = 31;
    localparam int ELAPSED_W   = 32;
    localparam int WDAY_W      = 3;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;
    localparam int SLOT_IDX_W  = 2;
    localparam int SLOT_WORD_W = 30;
    localparam int DAY_MIN_W   = 11;
    localparam int DAYS_W      = 7;
    localparam int CMP_W       = 26;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam int S_TDATA_W   = 112;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 8;

    localparam int MIN_PER_HOUR = 60;

    localparam int SLOT_EN_BIT  = 29;
    localparam int SLOT_DAY_LSB = 22;
    localparam int SLOT_ON_LSB  = 11;

    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOGGLE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONSUME    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE_SLOT = 3'd4;

    localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MANUAL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TIMER    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SENSOR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BUTTON   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_BELOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ON      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_OFF     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_CHK,
        ST_DONE
    } rmc_state_t;

    // Monday-based day number; a weekday code of 7 counts as Sunday.
    function automatic logic [WDAY_W-1:0] mon_day(input logic [WDAY_W-1:0] wd);
        logic [WDAY_W-1:0] d;
        unique case (wd)
            3'd0:    d = 3'd6;
            3'd1:    d = 3'd0;
            3'd2:    d = 3'd1;
            3'd3:    d = 3'd2;
            3'd4:    d = 3'd3;
            3'd5:    d = 3'd4;
            3'd6:    d = 3'd5;
            default: d = 3'd6;
        endcase
        return d;
    endfunction

    function automatic logic [WDAY_W-1:0] prev_day(input logic [WDAY_W-1:0] d);
        logic [WDAY_W-1:0] p;
        if (d == 3'd0) begin
            p = 3'd6;
        end else begin
            p = d - 3'd1;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### hdl/rmc_mod_unit.sv
// Restoring remainder unit: one quotient bit per cycle over the dividend width.
// Gives elapsed seconds modulo the timer period. Depends on rmc_pkg.
`default_nettype none

module rmc_mod_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rmc_pkg::ELAPSED_W-1:0] dividend,
    input  wire logic [rmc_pkg::ELAPSED_W-1:0] divisor,
    output logic                               done,
    output logic [rmc_pkg::ELAPSED_W-1:0]      remainder
);
    import rmc_pkg::*;

    localparam int CNT_W = $clog2(ELAPSED_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ELAPSED_W-1:0] dvd_reg;
    logic [ELAPSED_W-1:0] dsr_reg;
    logic [ELAPSED_W-1:0] rem_reg;
    logic [ELAPSED_W:0]   trial;
    logic [ELAPSED_W-1:0] rem_next;

    always_comb begin
        trial = {rem_reg, dvd_reg[ELAPSED_W-1]};
        if (trial >= {1'b0, dsr_reg}) begin
            rem_next = ELAPSED_W'(trial - {1'b0, dsr_reg});
        end else begin
            rem_next = trial[ELAPSED_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ELAPSED_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[ELAPSED_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hdl/rmc_slot_ram.sv
// Schedule slot memory: one write and one registered read port.
// Entries never written read as zero, that is as disabled slots. Depends on rmc_pkg.
`default_nettype none

module rmc_slot_ram #(
    parameter int SLOT_COUNT = 4,
    parameter int AW         = 2
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_en,
    input  wire logic [AW-1:0]                   wr_addr,
    input  wire logic [rmc_pkg::SLOT_WORD_W-1:0] wr_data,
    input  wire logic                            rd_en,
    input  wire logic [AW-1:0]                   rd_addr,
    output logic [rmc_pkg::SLOT_WORD_W-1:0]      rd_data
);
    import rmc_pkg::*;

    logic [SLOT_WORD_W-1:0] mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  valid_reg;
    logic [SLOT_WORD_W-1:0] rd_word_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

### hdl/relay_mode_controller.sv
// Relay mode controller top level: configuration registers, sequencer and decision logic.
// Instantiates rmc_mod_unit and rmc_slot_ram; depends on rmc_pkg.
//
//   channel   direction  handshake          payload
//   s_        in         s_tvalid/s_tready  s_tdata, s_tuser (command)
//   m_        out        m_tvalid/m_tready  m_tdata
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// A plain beat goes from ST_IDLE to ST_DONE; a timer tick waits in ST_DIV on the 32-step
// remainder unit, and a schedule tick reads and checks each slot in turn (ST_RD, ST_CHK).
// Reset is synchronous; it clears the relay state, the changed mark, the registers
// and the slot valid bits. A new beat is taken while a result waits on the m_ side;
// a stalled m_ side holds the next result in the sequencer until the output is free.
`default_nettype none

module relay_mode_controller #(
    parameter int SLOT_COUNT = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // set_value, sensor_value, sensor_ok, elapsed_seconds, time_valid, weekday,
    // hour, minute, button_edge, slot_index, slot_word, then zero fill
    input  wire logic [rmc_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [rmc_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // relay_on, pin_level, changed_flag, then zero fill
    output logic [rmc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rmc_pkg::*;

    localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_W   = (SLOT_AW > SLOT_IDX_W) ? SLOT_AW : SLOT_IDX_W;

    // Input field extraction.
    logic                    in_set_value;
    logic [SENSOR_W-1:0]     in_sensor_value;
    logic                    in_sensor_ok;
    logic [ELAPSED_W-1:0]    in_elapsed;
    logic                    in_time_valid;
    logic [WDAY_W-1:0]       in_weekday;
    logic [HOUR_W-1:0]       in_hour;
    logic [MINUTE_W-1:0]     in_minute;
    logic                    in_button_edge;
    logic [SLOT_IDX_W-1:0]   in_slot_index;
    logic [SLOT_WORD_W-1:0]  in_slot_word;
    logic [CMD_W-1:0]        in_cmd;

    assign in_set_value    = s_tdata[0];
    assign in_sensor_value = s_tdata[24:1];
    assign in_sensor_ok    = s_tdata[25];
    assign in_elapsed      = s_tdata[57:26];
    assign in_time_valid   = s_tdata[58];
    assign in_weekday      = s_tdata[61:59];
    assign in_hour         = s_tdata[66:62];
    assign in_minute       = s_tdata[72:67];
    assign in_button_edge  = s_tdata[73];
    assign in_slot_index   = s_tdata[75:74];
    assign in_slot_word    = s_tdata[105:76];
    assign in_cmd          = s_tuser[CMD_W-1:0];

    // Configuration registers.
    logic [MODE_W-1:0]          mode_reg;
    logic                       active_low_reg;
    logic                       compare_below_reg;
    logic signed [SENSOR_W-1:0] level_reg;
    logic [HYST_W-1:0]          hyst_reg;
    logic [SECS_W-1:0]          on_secs_reg;
    logic [SECS_W-1:0]          off_secs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_OFF;
            active_low_reg    <= 1'b0;
            compare_below_reg <= 1'b0;
            level_reg         <= '0;
            hyst_reg          <= '0;
            on_secs_reg       <= '0;
            off_secs_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:          mode_reg          <= cfg_wdata[MODE_W-1:0];
                CFG_ACTIVE_LOW:    active_low_reg    <= cfg_wdata[0];
                CFG_COMPARE_BELOW: compare_below_reg <= cfg_wdata[0];
                CFG_LEVEL:         level_reg         <= cfg_wdata[SENSOR_W-1:0];
                CFG_HYSTERESIS:    hyst_reg          <= cfg_wdata[HYST_W-1:0];
                CFG_TIMER_ON:      on_secs_reg       <= cfg_wdata[SECS_W-1:0];
                CFG_TIMER_OFF:     off_secs_reg      <= cfg_wdata[SECS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [ELAPSED_W-1:0] period;
    logic                 period_zero;

    assign period      = ELAPSED_W'(on_secs_reg) + ELAPSED_W'(off_secs_reg);
    assign period_zero = (period == '0);

    // Sequencer.
    rmc_state_t state_reg;
    rmc_state_t state_next;

    logic accept;
    logic in_is_tick;
    logic div_start;
    logic div_done;
    logic rd_en;
    logic out_load;
    logic slot_wr_en;
    logic last_slot;

    logic [SLOT_AW-1:0] scan_idx_reg;
    logic [IDX_W-1:0]   wr_idx_wide;

    logic m_valid_reg;

    assign accept      = s_tvalid && s_tready;
    assign in_is_tick  = (in_cmd == CMD_TICK);
    assign last_slot   = (scan_idx_reg == SLOT_AW'(SLOT_COUNT - 1));
    assign wr_idx_wide = IDX_W'(in_slot_index);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_is_tick && mode_reg == MODE_TIMER && !period_zero) begin
                        state_next = ST_DIV;
                    end else if (in_is_tick && mode_reg == MODE_SCHEDULE && in_time_valid) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (last_slot) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        div_start  = (state_reg == ST_IDLE) && s_tvalid && in_is_tick
                     && (mode_reg == MODE_TIMER) && !period_zero;
        rd_en      = (state_reg == ST_RD);
        out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
        slot_wr_en = (state_reg == ST_IDLE) && s_tvalid && (in_cmd == CMD_WRITE_SLOT)
                     && (32'(in_slot_index) < 32'(SLOT_COUNT));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Captured item fields.
    logic [CMD_W-1:0]           cmd_reg;
    logic                       set_value_reg;
    logic signed [SENSOR_W-1:0] sensor_reg;
    logic                       sensor_ok_reg;
    logic                       button_reg;
    logic [WDAY_W-1:0]          day_reg;
    logic [WDAY_W-1:0]          prev_day_reg;
    logic [DAY_MIN_W-1:0]       day_min_reg;
    logic [DAY_MIN_W-1:0]       day_min_c;
    logic                       hit_reg;
    logic                       slot_hit;

    assign day_min_c = DAY_MIN_W'(in_hour) * DAY_MIN_W'(MIN_PER_HOUR)
                       + DAY_MIN_W'(in_minute);

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= in_cmd;
            set_value_reg <= in_set_value;
            sensor_reg    <= in_sensor_value;
            sensor_ok_reg <= in_sensor_ok;
            button_reg    <= in_button_edge;
            day_reg       <= mon_day(in_weekday);
            prev_day_reg  <= prev_day(mon_day(in_weekday));
            day_min_reg   <= day_min_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hit_reg <= 1'b0;
        end else if (state_reg == ST_CHK) begin
            hit_reg <= hit_reg | slot_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
        end else if (accept) begin
            scan_idx_reg <= '0;
        end else if (state_reg == ST_CHK && !last_slot) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    // Slot memory and remainder unit.
    logic [SLOT_WORD_W-1:0] slot_rd_data;
    logic [ELAPSED_W-1:0]   remainder;

    rmc_slot_ram #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (SLOT_AW)
    ) u_slot_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (slot_wr_en),
        .wr_addr (wr_idx_wide[SLOT_AW-1:0]),
        .wr_data (in_slot_word),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (slot_rd_data)
    );

    rmc_mod_unit u_mod_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (in_elapsed),
        .divisor   (period),
        .done      (div_done),
        .remainder (remainder)
    );

    // Slot match for the entry read last cycle.
    logic                 slot_en;
    logic [DAYS_W-1:0]    slot_days;
    logic [DAY_MIN_W-1:0] slot_on;
    logic [DAY_MIN_W-1:0] slot_off;

    always_comb begin
        slot_en   = slot_rd_data[SLOT_EN_BIT];
        slot_days = slot_rd_data[SLOT_DAY_LSB +: DAYS_W];
        slot_on   = slot_rd_data[SLOT_ON_LSB +: DAY_MIN_W];
        slot_off  = slot_rd_data[DAY_MIN_W-1:0];
        slot_hit  = 1'b0;
        if (slot_en) begin
            if (slot_on < slot_off) begin
                slot_hit = slot_days[day_reg] && (day_min_reg >= slot_on)
                           && (day_min_reg < slot_off);
            end else begin
                slot_hit = (slot_days[day_reg] && (day_min_reg >= slot_on))
                           || (slot_days[prev_day_reg] && (day_min_reg < slot_off));
            end
        end
    end

    logic relay_reg;
    logic changed_reg;
    logic want;
    logic mark_next;
    logic flag_out;

    // Sensor comparison with the hysteresis band.
    logic signed [CMP_W-1:0] sens_v;
    logic signed [CMP_W-1:0] band_hi;
    logic signed [CMP_W-1:0] band_lo;
    logic                    at_hi;
    logic                    at_lo;
    logic                    sensor_want;

    always_comb begin
        sens_v  = CMP_W'(sensor_reg);
        band_hi = CMP_W'(level_reg) + $signed({4'b0, hyst_reg});
        band_lo = CMP_W'(level_reg) - $signed({4'b0, hyst_reg});
        at_hi   = (sens_v >= band_hi);
        at_lo   = (sens_v <= band_lo);
        sensor_want = relay_reg;
        if (sensor_ok_reg) begin
            if (!compare_below_reg) begin
                if (at_hi) begin
                    sensor_want = 1'b1;
                end else if (at_lo) begin
                    sensor_want = 1'b0;
                end
            end else begin
                if (at_lo) begin
                    sensor_want = 1'b1;
                end else if (at_hi) begin
                    sensor_want = 1'b0;
                end
            end
        end
    end

    // Relay decision.
    always_comb begin
        want = relay_reg;
        unique case (cmd_reg)
            CMD_TICK: begin
                unique case (mode_reg)
                    MODE_OFF:      want = 1'b0;
                    MODE_TIMER:    want = !period_zero
                                          && (remainder < ELAPSED_W'(on_secs_reg));
                    MODE_SENSOR:   want = sensor_want;
                    MODE_BUTTON:   want = relay_reg ^ button_reg;
                    MODE_SCHEDULE: want = hit_reg;
                    default:       want = relay_reg;
                endcase
            end
            CMD_SET:    want = set_value_reg;
            CMD_TOGGLE: want = !relay_reg;
            default:    want = relay_reg;
        endcase

        if (cmd_reg == CMD_CONSUME) begin
            flag_out  = changed_reg;
            mark_next = 1'b0;
        end else begin
            mark_next = changed_reg | (want != relay_reg);
            flag_out  = mark_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_reg   <= 1'b0;
            changed_reg <= 1'b0;
        end else if (out_load) begin
            relay_reg   <= want;
            changed_reg <= mark_next;
        end
    end

    // Output register.
    logic [M_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {(M_TDATA_W - 3)'(0), flag_out, want ^ active_low_reg, want};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An accepted beat always leaves idle.
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start processing");

    // The remainder unit only finishes while the sequencer waits on it.
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("remainder unit finished outside the timer wait");

    // Any change of the relay state leaves the changed mark set.
    a_change_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(relay_reg)) |-> changed_reg)
        else $error("relay changed without setting the changed mark");

    // A completed consume beat clears the changed mark.
    a_consume_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && cmd_reg == CMD_CONSUME) |=> !changed_reg)
        else $error("consume beat left the changed mark set");

    // The slot walk stays inside the table.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK) |-> (32'(scan_idx_reg) < 32'(SLOT_COUNT)))
        else $error("slot walk left the table");

endmodule

`default_nettype wire
